>>> rtl/rcic_pkg.sv
// rcic_pkg: shared types and constants for the rank count / insertion cost unit
// used by rcic_cell, rcic_cost and rank_count_insertion_cost_unit
package rcic_pkg;

  localparam int unsigned IN_VALUE_BITS  = 16;
  localparam int unsigned OUT_COUNT_BITS = 11;
  localparam int unsigned TOTAL_BITS     = 30;
  localparam logic [TOTAL_BITS:0] COST_MODULUS = 31'd1000000007;

  // control bits that travel with an item along the cell chain
  typedef struct packed {
    logic vld;
    logic last;
    logic placed;
  } ctl_t;

endpackage

>>> rtl/rcic_cell.sv
// rcic_cell: one storage slot of the chain; ranks the passing item against its
// stored value and takes the item if it is the first empty slot. uses rcic_pkg
module rcic_cell #(
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned CNT_BITS   = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  rcic_pkg::ctl_t        ctl_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [CNT_BITS-1:0]   below_i,
  input  logic [CNT_BITS-1:0]   above_i,
  output rcic_pkg::ctl_t        ctl_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic [CNT_BITS-1:0]   below_o,
  output logic [CNT_BITS-1:0]   above_o
);

  logic                  occ_r, occ_nxt;
  logic [VALUE_BITS-1:0] slot_r;
  rcic_pkg::ctl_t        ctl_r, ctl_nxt;
  logic [VALUE_BITS-1:0] value_r;
  logic [CNT_BITS-1:0]   below_r, below_nxt;
  logic [CNT_BITS-1:0]   above_r, above_nxt;
  logic                  take;
  logic                  lt, gt;

  assign take = ctl_i.vld && !occ_r && !ctl_i.placed;
  assign lt   = occ_r && (slot_r < value_i);
  assign gt   = occ_r && (slot_r > value_i);

  always_comb begin
    ctl_nxt        = ctl_i;
    ctl_nxt.placed = ctl_i.placed | take;
    below_nxt      = below_i + CNT_BITS'(lt);
    above_nxt      = above_i + CNT_BITS'(gt);
    occ_nxt        = occ_r;
    if (ctl_i.vld) begin
      // a last item empties the slot once it has gone by
      occ_nxt = ctl_i.last ? 1'b0 : (occ_r | take);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      ctl_r <= '0;
    end else if (adv) begin
      occ_r <= occ_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value_r <= value_i;
      below_r <= below_nxt;
      above_r <= above_nxt;
      if (take) begin
        slot_r <= value_i;
      end
    end
  end

  assign ctl_o   = ctl_r;
  assign value_o = value_r;
  assign below_o = below_r;
  assign above_o = above_r;

endmodule

>>> rtl/rcic_cost.sv
// rcic_cost: end of the chain; adds the smaller count to the running cost
// modulo 1000000007 and holds the result item. uses rcic_pkg
module rcic_cost #(
  parameter int unsigned CNT_BITS = 11
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rcic_pkg::ctl_t                       ctl_i,
  input  logic [CNT_BITS-1:0]                  below_i,
  input  logic [CNT_BITS-1:0]                  above_i,
  output logic                                 adv,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rcic_pkg::OUT_COUNT_BITS-1:0]  out_count_less,
  output logic [rcic_pkg::OUT_COUNT_BITS-1:0]  out_count_greater,
  output logic [rcic_pkg::TOTAL_BITS-1:0]      out_running_total,
  output logic                                 out_store_full
);

  localparam int unsigned OCB = rcic_pkg::OUT_COUNT_BITS;
  localparam int unsigned TB  = rcic_pkg::TOTAL_BITS;

  logic                out_valid_r, out_valid_nxt;
  logic [TB-1:0]       acc_r, acc_nxt;
  logic [OCB-1:0]      less_r, greater_r;
  logic [TB-1:0]       total_r;
  logic                full_r;
  logic [CNT_BITS-1:0] smaller;
  logic [TB:0]         sum, diff;
  logic [TB-1:0]       total;
  logic [CNT_BITS+OCB-1:0] below_ext, above_ext;

  assign adv = !out_valid_r || out_ready;

  assign smaller = (below_i < above_i) ? below_i : above_i;
  assign sum     = {1'b0, acc_r} + (TB+1)'(smaller);
  assign diff    = sum - rcic_pkg::COST_MODULUS;
  assign total   = (sum >= rcic_pkg::COST_MODULUS) ? diff[TB-1:0] : sum[TB-1:0];

  // counts wider than the field are masked
  assign below_ext = {{OCB{1'b0}}, below_i};
  assign above_ext = {{OCB{1'b0}}, above_i};

  always_comb begin
    out_valid_nxt = out_valid_r;
    acc_nxt       = acc_r;
    if (adv) begin
      out_valid_nxt = ctl_i.vld;
      if (ctl_i.vld) begin
        acc_nxt = ctl_i.last ? '0 : total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_i.vld) begin
      less_r    <= below_ext[OCB-1:0];
      greater_r <= above_ext[OCB-1:0];
      total_r   <= total;
      full_r    <= !ctl_i.placed;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_count_less    = less_r;
  assign out_count_greater = greater_r;
  assign out_running_total = total_r;
  assign out_store_full    = full_r;

endmodule

>>> rtl/rank_count_insertion_cost_unit.sv
// rank_count_insertion_cost_unit: top level; a chain of MAX_ITEMS rcic_cell slots
// followed by rcic_cost. uses rcic_pkg, rcic_cell, rcic_cost
//
// Each item walks a chain of MAX_ITEMS slots, one slot per cycle while the
// chain advances. Every occupied slot compares its stored value with the item
// and bumps the item's less/greater counts; the first empty slot on the way
// keeps the value. An item that finds no empty slot comes out with store_full
// set. At the end of the chain the smaller count is added to the running cost
// modulo 1000000007. Each slot registers the item, and rcic_cost registers the
// result; a new item is taken every cycle while the result side keeps up, and
// the whole chain holds while a result waits. A last item empties every slot
// as it passes and clears the cost once its result is formed. No clearing
// pass follows reset.
module rank_count_insertion_cost_unit #(
  parameter int unsigned MAX_ITEMS  = 1024,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rcic_pkg::IN_VALUE_BITS-1:0]   in_value,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rcic_pkg::OUT_COUNT_BITS-1:0]  out_count_less,
  output logic [rcic_pkg::OUT_COUNT_BITS-1:0]  out_count_greater,
  output logic [rcic_pkg::TOTAL_BITS-1:0]      out_running_total,
  output logic                                 out_store_full
);

  localparam int unsigned CNT_BITS = $clog2(MAX_ITEMS + 1);
  localparam int unsigned EXT_BITS = rcic_pkg::IN_VALUE_BITS + VALUE_BITS;

  logic                  adv;
  rcic_pkg::ctl_t        ctl_w   [0:MAX_ITEMS];
  logic [VALUE_BITS-1:0] value_w [0:MAX_ITEMS];
  logic [CNT_BITS-1:0]   below_w [0:MAX_ITEMS];
  logic [CNT_BITS-1:0]   above_w [0:MAX_ITEMS];
  logic [EXT_BITS-1:0]   in_ext;

  // only the low VALUE_BITS bits of the value take part
  assign in_ext = {{VALUE_BITS{1'b0}}, in_value};

  assign in_ready       = adv;
  assign ctl_w[0].vld    = in_valid;
  assign ctl_w[0].last   = in_last;
  assign ctl_w[0].placed = 1'b0;
  assign value_w[0]     = in_ext[VALUE_BITS-1:0];
  assign below_w[0]     = '0;
  assign above_w[0]     = '0;

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    rcic_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_BITS   (CNT_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .ctl_i   (ctl_w[g]),
      .value_i (value_w[g]),
      .below_i (below_w[g]),
      .above_i (above_w[g]),
      .ctl_o   (ctl_w[g+1]),
      .value_o (value_w[g+1]),
      .below_o (below_w[g+1]),
      .above_o (above_w[g+1])
    );
  end

  rcic_cost #(
    .CNT_BITS (CNT_BITS)
  ) u_cost (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl_i             (ctl_w[MAX_ITEMS]),
    .below_i           (below_w[MAX_ITEMS]),
    .above_i           (above_w[MAX_ITEMS]),
    .adv               (adv),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_count_less    (out_count_less),
    .out_count_greater (out_count_greater),
    .out_running_total (out_running_total),
    .out_store_full    (out_store_full)
  );

endmodule
